// File: rtl/core/bfsf_pkg.sv
// ----------------------------------------------------------------------------
// bfsf_pkg
// Shared types and constants of the band free segment finder.
// ----------------------------------------------------------------------------
package bfsf_pkg;

   localparam int MaxRects   = 16;
   localparam int CoordWidth = 24;
   localparam int WidthBits  = CoordWidth - 1;
   localparam int IdxBits    = $clog2(MaxRects);
   localparam int CntBits    = $clog2(MaxRects + 1);
   localparam int QDepth     = 2;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]                   op;
      logic signed [CoordWidth-1:0] rect_left;
      logic signed [CoordWidth-1:0] rect_top;
      logic signed [CoordWidth-1:0] rect_right;
      logic signed [CoordWidth-1:0] rect_bottom;
      logic signed [CoordWidth-1:0] band_top;
      logic [WidthBits-1:0]         band_height;
      logic signed [CoordWidth-1:0] line_min_x;
      logic signed [CoordWidth-1:0] line_max_x;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] seg_start;
      logic [WidthBits-1:0]         seg_width;
      logic                         seg_valid;
      logic                         last;
      logic                         status;
   } rsp_type;

   // command handed from the front to the back through the queue
   typedef struct packed {
      logic [1:0]                   op;
      logic                         full;
      logic signed [CoordWidth:0]   band_top;
      logic signed [CoordWidth:0]   band_bot;
      logic signed [CoordWidth-1:0] line_min_x;
      logic signed [CoordWidth-1:0] line_max_x;
   } cmd_type;

endpackage

// File: rtl/core/bfsf_front.sv
// ----------------------------------------------------------------------------
// bfsf_front
// Accepts items, writes added rectangles into the store, tracks the count
// and queues one command per add, query or clear item for the back end.
// ----------------------------------------------------------------------------
module bfsf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bfsf_pkg::req_type req_data,
   output logic              q_valid,
   input  logic              q_pop,
   output bfsf_pkg::cmd_type q_data,
   input  logic              back_busy,
   output logic [bfsf_pkg::CntBits-1:0] count,
   output logic              wr_en,
   output logic [bfsf_pkg::IdxBits-1:0] wr_addr
);
   import bfsf_pkg::*;

   logic [CntBits-1:0] count_ff, count_in;
   cmd_type            queue_ff [QDepth];
   cmd_type            queue_in [QDepth];
   logic [1:0]         fill_ff, fill_in;
   logic               take, push;
   logic               slot;
   cmd_type            cmd;

   // queries read the store, so adds and clears wait until the back is idle
   // and the queue is empty; this keeps the store coherent with each query
   assign req_stall = (fill_ff == 2'(QDepth)) ||
                      ((req_data.op == OP_ADD || req_data.op == OP_CLEAR) &&
                       (fill_ff != 2'd0 || back_busy));
   assign take = req_valid && !req_stall;
   assign push = take && (req_data.op != OP_NONE);

   always_comb begin
      cmd            = '0;
      cmd.op         = req_data.op;
      cmd.full       = (count_ff == CntBits'(MaxRects));
      cmd.band_top   = (CoordWidth+1)'(req_data.band_top);
      cmd.band_bot   = (CoordWidth+1)'(req_data.band_top) +
                       (CoordWidth+1)'({1'b0, req_data.band_height});
      cmd.line_min_x = req_data.line_min_x;
      cmd.line_max_x = req_data.line_max_x;
   end

   assign wr_en   = take && req_data.op == OP_ADD && !cmd.full;
   assign wr_addr = count_ff[IdxBits-1:0];
   assign count   = count_ff;

   always_comb begin
      count_in = count_ff;
      if (wr_en) begin
         count_in = count_ff + 1'b1;
      end else if (take && req_data.op == OP_CLEAR) begin
         count_in = '0;
      end
   end

   assign fill_in = fill_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
      end
   end

   // two-entry queue, head at slot 0; a push never meets a full queue
   assign slot = fill_ff[0] && !q_pop;

   always_comb begin
      queue_in = queue_ff;
      if (q_pop) begin
         queue_in[0] = queue_ff[1];
      end
      if (push) begin
         queue_in[slot] = cmd;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   assign q_valid = fill_ff != 2'd0;
   assign q_data  = queue_ff[0];
endmodule

// File: rtl/core/bfsf_back.sv
// ----------------------------------------------------------------------------
// bfsf_back
// Runs one command: add and clear give a single response, a query picks
// the overlapping rectangles in left order, one per pass, and sweeps gaps.
// ----------------------------------------------------------------------------
module bfsf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  bfsf_pkg::cmd_type q_data,
   output logic              busy,
   input  logic [bfsf_pkg::CntBits-1:0] count,
   input  logic [bfsf_pkg::WidthBits-1:0] min_width,
   input  logic signed [bfsf_pkg::CoordWidth-1:0] st_left  [bfsf_pkg::MaxRects],
   input  logic signed [bfsf_pkg::CoordWidth-1:0] st_right [bfsf_pkg::MaxRects],
   input  logic signed [bfsf_pkg::CoordWidth-1:0] st_top   [bfsf_pkg::MaxRects],
   input  logic signed [bfsf_pkg::CoordWidth-1:0] st_bot   [bfsf_pkg::MaxRects],
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bfsf_pkg::rsp_type rsp_data
);
   import bfsf_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PICK = 3'd1;
   localparam logic [2:0] S_STEP = 3'd2;
   localparam logic [2:0] S_TAIL = 3'd3;
   localparam logic [2:0] S_LAST = 3'd4;

   localparam int XW = CoordWidth + 2;

   logic [2:0]                   state_ff, state_in;
   cmd_type                      cmd_ff;
   logic [MaxRects-1:0]          pend_ff, pend_in;
   logic signed [XW-1:0]         cur_ff, cur_in;
   logic signed [CoordWidth-1:0] pl_ff, pr_ff;
   logic                         gp_v_ff, gp_v_in;
   logic signed [XW-1:0]         gp_s_ff, gp_s_in;
   logic signed [XW-1:0]         gp_w_ff, gp_w_in;
   logic                         out_v_ff, out_v_in;
   rsp_type                      out_ff, out_in;
   logic [MaxRects-1:0]          hit;
   logic [IdxBits-1:0]           tr_idx  [MaxRects];
   logic                         tr_v    [MaxRects];
   logic signed [CoordWidth-1:0] tr_left [MaxRects];
   logic [IdxBits-1:0]           best;
   logic                         any;
   logic signed [XW-1:0]         lo, hi, l, r, tail, mw;
   logic                         new_gap, tail_gap;
   logic                         free;

   assign free = !out_v_ff || !rsp_stall;

   // rectangles overlapping the band
   always_comb begin
      for (int i = 0; i < MaxRects; i++) begin
         hit[i] = (i < int'(count)) &&
                  !((CoordWidth+1)'(st_bot[i]) <= q_data.band_top ||
                    (CoordWidth+1)'(st_top[i]) >= q_data.band_bot);
      end
   end

   // earliest smallest left edge among pending entries, pairwise tree;
   // the lower index side wins ties
   always_comb begin
      for (int i = 0; i < MaxRects; i++) begin
         tr_idx[i]  = IdxBits'(i);
         tr_v[i]    = pend_ff[i];
         tr_left[i] = st_left[i];
      end
      for (int s = 1; s < MaxRects; s = s * 2) begin
         for (int i = 0; i + s < MaxRects; i = i + 2 * s) begin
            if (tr_v[i + s] && (!tr_v[i] || tr_left[i + s] < tr_left[i])) begin
               tr_idx[i]  = tr_idx[i + s];
               tr_left[i] = tr_left[i + s];
               tr_v[i]    = 1'b1;
            end
         end
      end
      best = tr_idx[0];
      any  = tr_v[0];
   end

   assign lo = XW'(cmd_ff.line_min_x);
   assign hi = XW'(cmd_ff.line_max_x);
   assign mw = XW'({1'b0, min_width});
   assign l  = (XW'(pl_ff) > lo) ? XW'(pl_ff) : lo;
   assign r  = (XW'(pr_ff) < hi) ? XW'(pr_ff) : hi;

   assign new_gap  = (l > cur_ff) && ((l - cur_ff) >= mw);
   assign tail     = hi - cur_ff;
   assign tail_gap = tail >= mw;

   function automatic rsp_type mk_gap(logic signed [XW-1:0] s,
                                      logic signed [XW-1:0] w, logic lst);
      rsp_type o;
      o.seg_start = s[CoordWidth-1:0];
      o.seg_width = (w > XW'({1'b0, {WidthBits{1'b1}}})) ? {WidthBits{1'b1}}
                                                          : w[WidthBits-1:0];
      o.seg_valid = 1'b1;
      o.last      = lst;
      o.status    = 1'b0;
      return o;
   endfunction

   // each gap waits in the pending slot until the next one shows up, so the
   // final gap can still be marked last when the sweep ends
   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cur_in   = cur_ff;
      gp_v_in  = gp_v_ff;
      gp_s_in  = gp_s_ff;
      gp_w_in  = gp_w_ff;
      out_v_in = out_v_ff && rsp_stall;
      out_in   = out_ff;
      q_pop    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && free) begin
               q_pop = 1'b1;
               if (q_data.op == OP_QUERY) begin
                  pend_in  = hit;
                  cur_in   = XW'(q_data.line_min_x);
                  gp_v_in  = 1'b0;
                  state_in = S_PICK;
               end else begin
                  out_v_in = 1'b1;
                  out_in   = '0;
                  out_in.last   = 1'b1;
                  out_in.status = (q_data.op == OP_ADD) && q_data.full;
               end
            end
         end
         S_PICK: begin
            if (any) begin
               pend_in[best] = 1'b0;
               state_in = S_STEP;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_STEP: begin
            if (r <= cur_ff) begin
               state_in = S_PICK;
            end else if (!(new_gap && gp_v_ff && !free)) begin
               if (new_gap) begin
                  if (gp_v_ff) begin
                     out_v_in = 1'b1;
                     out_in   = mk_gap(gp_s_ff, gp_w_ff, 1'b0);
                  end
                  gp_v_in = 1'b1;
                  gp_s_in = cur_ff;
                  gp_w_in = l - cur_ff;
               end
               cur_in   = r;
               state_in = (r >= hi) ? S_TAIL : S_PICK;
            end
         end
         S_TAIL: begin
            if (!(tail_gap && gp_v_ff && !free)) begin
               if (tail_gap) begin
                  if (gp_v_ff) begin
                     out_v_in = 1'b1;
                     out_in   = mk_gap(gp_s_ff, gp_w_ff, 1'b0);
                  end
                  gp_v_in = 1'b1;
                  gp_s_in = cur_ff;
                  gp_w_in = tail;
               end
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            if (free) begin
               out_v_in = 1'b1;
               if (gp_v_ff) begin
                  out_in = mk_gap(gp_s_ff, gp_w_ff, 1'b1);
               end else begin
                  out_in      = '0;
                  out_in.last = 1'b1;
               end
               gp_v_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = state_ff != S_IDLE || out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         gp_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         gp_v_ff  <= gp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      cur_ff  <= cur_in;
      gp_s_ff <= gp_s_in;
      gp_w_ff <= gp_w_in;
      out_ff  <= out_in;
      if (state_ff == S_PICK && any) begin
         pl_ff <= tr_left[0];
         pr_ff <= st_right[best];
      end
      if (state_ff == S_IDLE) begin
         cmd_ff <= q_data;
      end
   end
endmodule

// File: rtl/core/band_free_segment_finder.sv
// ----------------------------------------------------------------------------
// band_free_segment_finder
// Rectangle store plus free-gap search for one text line band.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req     | in  | valid / stall | req_type
//  rsp     | out | valid / stall | rsp_type
//  csr     | in  | valid / ready | min_width
//
// Add and clear: the result passes through the command queue and the output
// register before it is offered. A query offers its final result once the
// one-per-pass left-edge selection has taken each rectangle in the band, or
// sooner when the sweep reaches the span end.
// Reset is synchronous and empties the store. Response stalls hold the back
// end; adds and clears wait while any command is queued or running.
// ----------------------------------------------------------------------------
module band_free_segment_finder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bfsf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bfsf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [bfsf_pkg::WidthBits-1:0] csr_data
);
   import bfsf_pkg::*;

   logic                  q_valid, q_pop, busy, wr_en;
   cmd_type               q_data;
   logic [CntBits-1:0]    count;
   logic [IdxBits-1:0]    wr_addr;
   logic [WidthBits-1:0]  min_width_ff;
   logic signed [CoordWidth-1:0] left_ff [MaxRects];
   logic signed [CoordWidth-1:0] right_ff[MaxRects];
   logic signed [CoordWidth-1:0] top_ff  [MaxRects];
   logic signed [CoordWidth-1:0] bot_ff  [MaxRects];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= '0;
      end else if (csr_valid) begin
         min_width_ff <= csr_data;
      end
   end

   // rectangle store, one register row per entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_ff[wr_addr]  <= req_data.rect_left;
         right_ff[wr_addr] <= req_data.rect_right;
         top_ff[wr_addr]   <= req_data.rect_top;
         bot_ff[wr_addr]   <= req_data.rect_bottom;
      end
   end

   bfsf_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_pop, .q_data, .back_busy(busy), .count, .wr_en, .wr_addr
   );

   bfsf_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data, .busy, .count,
      .min_width(min_width_ff), .st_left(left_ff), .st_right(right_ff),
      .st_top(top_ff), .st_bot(bot_ff), .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

// File: rtl/core/bfsf_checker.sv
// ----------------------------------------------------------------------------
// bfsf_checker
// Port-level checks of the band free segment finder.
// ----------------------------------------------------------------------------
module bfsf_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bfsf_pkg::rsp_type rsp_data
);
   import bfsf_pkg::*;

   // a held response keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a response without a gap is always final
   a_nogap_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.seg_valid |-> rsp_data.last)
      else $error("empty response not final");

   // only adds report full, never with a gap
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> !rsp_data.seg_valid)
      else $error("status set on a gap");

   // no response right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response out of reset");
endmodule

bind band_free_segment_finder bfsf_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data
);

// File: dv/tb_band_free_segment_finder.sv
// ----------------------------------------------------------------------------
// tb_band_free_segment_finder
// Self-checking bench: directed and random adds, clears and band queries,
// results compared field by field against an in-bench gap predictor.
// ----------------------------------------------------------------------------
module tb_band_free_segment_finder;
   import bfsf_pkg::*;

   localparam int WMAX    = (1 << WidthBits) - 1;
   localparam int ReqBits = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [WidthBits-1:0] csr_data;

   // predictor state
   logic signed [CoordWidth-1:0] rect_l[MaxRects];
   logic signed [CoordWidth-1:0] rect_t[MaxRects];
   logic signed [CoordWidth-1:0] rect_r[MaxRects];
   logic signed [CoordWidth-1:0] rect_b[MaxRects];
   int                           rect_cnt;
   logic [WidthBits-1:0]         gap_min;

   rsp_type gap_queue[$];
   int      errors = 0;
   int      hold_reqs;
   int      hold_done;
   int      hold_cycles;

   band_free_segment_finder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   function automatic rsp_type mk_rsp(longint s, longint w, bit v, bit l, bit st);
      rsp_type r;
      if (w > longint'(WMAX)) w = longint'(WMAX);
      if (w < 0) w = 0;
      r.seg_start = s[CoordWidth-1:0];
      r.seg_width = w[WidthBits-1:0];
      r.seg_valid = v;
      r.last      = l;
      r.status    = st;
      return r;
   endfunction

   // compute expected results for one accepted item
   task automatic predict_gaps(req_type q);
      longint sl[MaxRects];
      longint sr[MaxRects];
      longint gs[$];
      longint gw[$];
      longint btop, bbot, lo, hi, cur, l, r, mw;
      int     n, j;
      n = 0;
      case (q.op)
         OP_ADD: begin
            if (rect_cnt < MaxRects) begin
               rect_l[rect_cnt] = q.rect_left;
               rect_t[rect_cnt] = q.rect_top;
               rect_r[rect_cnt] = q.rect_right;
               rect_b[rect_cnt] = q.rect_bottom;
               rect_cnt++;
               gap_queue.push_back(mk_rsp(0, 0, 0, 1, 0));
            end else begin
               gap_queue.push_back(mk_rsp(0, 0, 0, 1, 1));
            end
         end
         OP_CLEAR: begin
            rect_cnt = 0;
            gap_queue.push_back(mk_rsp(0, 0, 0, 1, 0));
         end
         OP_QUERY: begin
            btop = longint'(q.band_top);
            bbot = btop + longint'(q.band_height);
            lo   = longint'(q.line_min_x);
            hi   = longint'(q.line_max_x);
            mw   = longint'(gap_min);
            cur  = lo;
            // stable insertion by left edge
            for (int i = 0; i < rect_cnt; i++) begin
               if (longint'(rect_b[i]) <= btop || longint'(rect_t[i]) >= bbot) continue;
               j = n;
               while (j > 0 && sl[j-1] > longint'(rect_l[i])) begin
                  sl[j] = sl[j-1];
                  sr[j] = sr[j-1];
                  j--;
               end
               sl[j] = longint'(rect_l[i]);
               sr[j] = longint'(rect_r[i]);
               n++;
            end
            // cursor sweep
            for (int i = 0; i < n; i++) begin
               l = (sl[i] > lo) ? sl[i] : lo;
               r = (sr[i] < hi) ? sr[i] : hi;
               if (r <= cur) continue;
               if (l > cur && l - cur >= mw && gs.size() < 17) begin
                  gs.push_back(cur);
                  gw.push_back(l - cur);
               end
               cur = r;
               if (cur >= hi) break;
            end
            if (hi - cur >= mw && gs.size() < 17) begin
               gs.push_back(cur);
               gw.push_back(hi - cur);
            end
            if (gs.size() == 0)
               gap_queue.push_back(mk_rsp(0, 0, 0, 1, 0));
            else
               foreach (gs[k])
                  gap_queue.push_back(mk_rsp(gs[k], gw[k], 1, k == gs.size() - 1, 0));
         end
         default: ;
      endcase
   endtask

   // sender: one transfer with a random gap before it
   task automatic send_item(req_type q);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_gaps(q);
   endtask

   // wait until all expected results are in, then settle
   task automatic drain;
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (gap_queue.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic write_min_width(logic [WidthBits-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      gap_min = v;
      csr_valid <= 1'b0;
   endtask

   function automatic req_type mk_add(int l, int t, int r, int b);
      req_type q;
      q = '0;
      q.op = OP_ADD;
      q.rect_left   = CoordWidth'(l);
      q.rect_top    = CoordWidth'(t);
      q.rect_right  = CoordWidth'(r);
      q.rect_bottom = CoordWidth'(b);
      return q;
   endfunction

   function automatic req_type mk_query(int bt, int bh, int lo, int hi);
      req_type q;
      q = '0;
      q.op = OP_QUERY;
      q.band_top    = CoordWidth'(bt);
      q.band_height = WidthBits'(bh);
      q.line_min_x  = CoordWidth'(lo);
      q.line_max_x  = CoordWidth'(hi);
      return q;
   endfunction

   function automatic req_type mk_clear();
      req_type q;
      q = '0;
      q.op = OP_CLEAR;
      return q;
   endfunction

   // random content on every field, op chosen by caller
   function automatic req_type rand_item(logic [1:0] op);
      req_type q;
      q = ReqBits'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom});
      q.op = op;
      if ($urandom_range(0, 3) != 0) begin
         q.rect_left   = CoordWidth'($signed($urandom_range(0, 4000)) - 2000);
         q.rect_right  = CoordWidth'(q.rect_left + $signed($urandom_range(0, 800)) - 50);
         q.rect_top    = CoordWidth'($signed($urandom_range(0, 2000)) - 1000);
         q.rect_bottom = CoordWidth'(q.rect_top + $signed($urandom_range(0, 600)) - 20);
         q.band_top    = CoordWidth'($signed($urandom_range(0, 2000)) - 1000);
         q.band_height = WidthBits'($urandom_range(0, 700));
         q.line_min_x  = CoordWidth'($signed($urandom_range(0, 2000)) - 2200);
         q.line_max_x  = CoordWidth'(q.line_min_x + $signed($urandom_range(0, 4500)) - 100);
      end
      return q;
   endfunction

   task automatic test_directed_extremes;
      send_item(mk_query(0, 100, 0, 1000));              // empty store
      send_item(mk_query(0, 0, 5, 5));                    // equal limits, zero gap
      send_item(mk_query(0, 0, 10, -10));                 // reversed span
      send_item(mk_add(100, 0, 200, 50));
      send_item(mk_add(100, 10, 150, 40));                // tie on left edge
      send_item(mk_add(300, 0, 250, 50));                 // degenerate width
      send_item(mk_add(-8388608, -8388608, 8388607, 8388607));
      send_item(mk_query(20, 10, 0, 1000));
      send_item(mk_query(8388607, 8388607, -8388608, 8388607));
      send_item(mk_query(-8388608, 0, -8388608, 8388607));
      send_item(mk_clear());
      send_item(mk_add(-8388608, 0, -8388608, 10));
      send_item(mk_add(500, 50, 600, 0));                 // degenerate height
      send_item(mk_query(0, 20, -8388608, 8388607));      // saturated width
      send_item(mk_query(0, 20, 0, 0));
      send_item(rand_item(OP_NONE));                      // unused op ignored
      send_item(mk_clear());
   endtask

   task automatic test_store_full;
      for (int i = 0; i < MaxRects + 2; i++)
         send_item(mk_add(i * 60, 0, i * 60 + 30, 100));
      send_item(mk_query(10, 10, -100, 2000));            // many gaps
      send_item(mk_clear());
   endtask

   task automatic test_min_width;
      write_min_width(WidthBits'(40));
      send_item(mk_add(100, 0, 130, 100));
      send_item(mk_add(160, 0, 200, 100));
      send_item(mk_query(0, 50, 0, 400));
      write_min_width(WidthBits'(WMAX));
      send_item(mk_query(0, 50, 0, 400));
      send_item(mk_query(0, 50, -8388608, 8388607));
      write_min_width(WidthBits'(0));
      send_item(mk_clear());
   endtask

   task automatic test_random;
      int r;
      for (int i = 0; i < 60; i++) begin
         if (i == 20) write_min_width(WidthBits'($urandom_range(0, 200)));
         if (i == 40) write_min_width(WidthBits'($urandom_range(0, WMAX)));
         if (i == 52) write_min_width(WidthBits'(0));
         r = $urandom_range(0, 19);
         if (r < 9)       send_item(rand_item(OP_ADD));
         else if (r < 17) send_item(rand_item(OP_QUERY));
         else if (r < 19) send_item(rand_item(OP_CLEAR));
         else             send_item(rand_item(OP_NONE));
      end
   endtask

   // long receiver hold-off while the sender keeps offering
   task automatic test_backpressure;
      hold_reqs++;
      for (int i = 0; i < 12; i++)
         send_item(rand_item(i % 3 == 2 ? OP_QUERY : OP_ADD));
   endtask

   // receiver stall process
   initial begin
      rsp_stall   = 1'b0;
      hold_cycles = 0;
      hold_done   = 0;
      forever begin
         @(posedge clock);
         if (hold_reqs != hold_done) begin
            hold_done   = hold_reqs;
            hold_cycles = 400;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 40) == 0);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (gap_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            want = gap_queue.pop_front();
            if (rsp_data.seg_start !== want.seg_start) begin
               $display("%0t: seg_start exp %0d got %0d", $time, want.seg_start,
                        rsp_data.seg_start);
               errors++;
            end
            if (rsp_data.seg_width !== want.seg_width) begin
               $display("%0t: seg_width exp %0d got %0d", $time, want.seg_width,
                        rsp_data.seg_width);
               errors++;
            end
            if (rsp_data.seg_valid !== want.seg_valid) begin
               $display("%0t: seg_valid exp %0b got %0b", $time, want.seg_valid,
                        rsp_data.seg_valid);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t: last exp %0b got %0b", $time, want.last, rsp_data.last);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status exp %0b got %0b", $time, want.status,
                        rsp_data.status);
               errors++;
            end
         end
      end
   end

   initial begin
      hold_reqs = 0;
      rect_cnt  = 0;
      gap_min   = '0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_store_full();
      test_min_width();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0 && gap_queue.size() == 0)
         $display("PASS band_free_segment_finder");
      else
         $display("FAIL band_free_segment_finder");
      $finish;
   end

   initial begin
      #9000000;
      $display("FAIL band_free_segment_finder");
      $finish;
   end

endmodule

// File: files.f
rtl/core/bfsf_pkg.sv
rtl/core/bfsf_front.sv
rtl/core/bfsf_back.sv
rtl/core/band_free_segment_finder.sv
rtl/core/bfsf_checker.sv
dv/tb_band_free_segment_finder.sv
